/* hdl/postfix_expression_evaluator_unit_macros.svh */
// assertion macros for the postfix evaluator
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PSX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("postfix evaluator check failed");
// next-cycle implication
`define PSX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("postfix evaluator check failed");
`else
`define PSX_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSX_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/psx_pkg.sv */
package psx_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int RESULT_W    = 32;
  localparam int SYMBOL_W    = 8;
  localparam int STATUS_W    = 2;

  localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 8'h30;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LEFT  = 2'd3;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP
  } shift_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_e;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic [STATUS_W-1:0]        status;
  } res_t;

endpackage

/* hdl/psx_cell.sv */
// one stack entry; shifts towards the top or the bottom with its neighbours
module psx_cell (
  input  logic            clk_i,
  input  psx_pkg::shift_e shift_i,
  input  psx_pkg::value_t prev_i,
  input  psx_pkg::value_t next_i,
  output psx_pkg::value_t value_o
);

  psx_pkg::value_t val_d, val_q;

  always_comb begin
    case (shift_i)
      psx_pkg::SH_PUSH: val_d = prev_i;
      psx_pkg::SH_POP:  val_d = next_i;
      default:          val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;

endmodule

/* hdl/psx_alu.sv */
// wrapping add, subtract and multiply on the two top entries
module psx_alu (
  input  psx_pkg::alu_op_e op_i,
  input  psx_pkg::value_t  lower_i,
  input  psx_pkg::value_t  top_i,
  output psx_pkg::value_t  result_o
);

  always_comb begin
    unique case (op_i)
      psx_pkg::ALU_ADD: result_o = lower_i + top_i;
      psx_pkg::ALU_SUB: result_o = lower_i - top_i;
      // low half of the product only, the wrap drops the rest
      psx_pkg::ALU_MUL: result_o = lower_i * top_i;
      default:          result_o = lower_i + top_i;
    endcase
  end

endmodule

/* hdl/psx_obuf.sv */
// output register with one skid slot behind it
module psx_obuf (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  psx_pkg::res_t data_i,
  output logic         full_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output psx_pkg::res_t data_o
);

  logic         out_valid_d, out_valid_q;
  logic         skid_valid_d, skid_valid_q;
  psx_pkg::res_t out_d, out_q;
  psx_pkg::res_t skid_d, skid_q;
  logic         take;

  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_o      = out_q;

endmodule

/* hdl/postfix_expression_evaluator_unit.sv */
// result: registered when its last character is taken, in the skid slot if the output register is unread
// throughput: one character per cycle when not stalled; top cell -> alu -> top cell loop of the stack
// input stalls only while a result sits in the skid slot behind an unread output register
// reset: asynchronous, active low; clears the fill count, the error code and the output valids
// the stack cells themselves are not cleared, the fill count alone marks which hold operands
`include "postfix_expression_evaluator_unit_macros.svh"

module postfix_expression_evaluator_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // character channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [psx_pkg::SYMBOL_W-1:0]          symbol_i,
  input  logic                                  last_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [psx_pkg::RESULT_W-1:0]   result_o,
  output logic [psx_pkg::STATUS_W-1:0]          status_o
);

  // fill count and first error of the current expression
  logic [psx_pkg::CNT_W-1:0]    cnt_d, cnt_q;
  logic [psx_pkg::STATUS_W-1:0] err_d, err_q;

  logic              in_fire;
  logic              is_op;
  psx_pkg::alu_op_e  alu_op;
  psx_pkg::value_t   push_val;
  psx_pkg::value_t   alu_res;
  psx_pkg::value_t   head_val;
  psx_pkg::value_t   top_new;
  psx_pkg::shift_e   shift;
  psx_pkg::res_t     res;
  psx_pkg::res_t     res_out;
  logic              obuf_full;
  logic [psx_pkg::CNT_W-1:0]    cnt_new;
  logic [psx_pkg::STATUS_W-1:0] err_new;

  // cell 0 is the top of stack, cell 1 the entry below it
  psx_pkg::value_t cell_val [psx_pkg::STACK_DEPTH];

  // a transfer is taken whenever the skid slot is free
  assign in_stall_o = obuf_full;
  assign in_fire    = in_valid_i && !in_stall_o;

  // operator decode
  always_comb begin
    is_op  = 1'b1;
    alu_op = psx_pkg::ALU_ADD;
    unique case (symbol_i)
      psx_pkg::CHAR_PLUS:  alu_op = psx_pkg::ALU_ADD;
      psx_pkg::CHAR_MINUS: alu_op = psx_pkg::ALU_SUB;
      psx_pkg::CHAR_STAR:  alu_op = psx_pkg::ALU_MUL;
      default:             is_op  = 1'b0;
    endcase
  end

  // any non-operator pushes its code minus ascii zero, wrapping
  assign push_val = psx_pkg::VALUE_WIDTH'(symbol_i) - psx_pkg::VALUE_WIDTH'(psx_pkg::CHAR_ZERO);

  // lower minus top, lower times top
  psx_alu u_alu (
    .op_i     (alu_op),
    .lower_i  (cell_val[1]),
    .top_i    (cell_val[0]),
    .result_o (alu_res)
  );

  // stack control: while no error is recorded, a push shifts everything down,
  // an operator folds the top two into one and shifts the rest up
  always_comb begin
    shift   = psx_pkg::SH_HOLD;
    head_val = push_val;
    cnt_new = cnt_q;
    err_new = err_q;
    if (err_q == psx_pkg::ST_OK) begin
      if (is_op) begin
        head_val = alu_res;
        if (cnt_q < psx_pkg::CNT_W'(2)) begin
          err_new = psx_pkg::ST_UNDER;
        end else begin
          shift   = psx_pkg::SH_POP;
          cnt_new = cnt_q - psx_pkg::CNT_W'(1);
        end
      end else begin
        if (cnt_q >= psx_pkg::CNT_W'(psx_pkg::STACK_DEPTH)) begin
          err_new = psx_pkg::ST_OVER;
        end else begin
          shift   = psx_pkg::SH_PUSH;
          cnt_new = cnt_q + psx_pkg::CNT_W'(1);
        end
      end
    end
    if (!in_fire) begin
      shift = psx_pkg::SH_HOLD;
    end
  end

  // top of stack as it stands once this character is taken
  assign top_new = (shift == psx_pkg::SH_HOLD) ? cell_val[0] : head_val;

  // final value and status for the last character
  always_comb begin
    res.result = '0;
    if (err_new != psx_pkg::ST_OK) begin
      res.status = err_new;
    end else if (cnt_new == '0) begin
      res.status = psx_pkg::ST_UNDER;
    end else begin
      res.result = psx_pkg::RESULT_W'($signed(top_new));
      res.status = (cnt_new > psx_pkg::CNT_W'(1)) ? psx_pkg::ST_LEFT : psx_pkg::ST_OK;
    end
  end

  // stack is emptied after every expression
  always_comb begin
    cnt_d = cnt_q;
    err_d = err_q;
    if (in_fire) begin
      if (last_i) begin
        cnt_d = '0;
        err_d = psx_pkg::ST_OK;
      end else begin
        cnt_d = cnt_new;
        err_d = err_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= psx_pkg::ST_OK;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

  // row of stack cells; the top cell loads the new head on either shift
  for (genvar i = 0; i < psx_pkg::STACK_DEPTH; i++) begin : g_cell
    psx_pkg::value_t prev_val, next_val;
    if (i == 0) begin : g_top
      assign prev_val = head_val;
      assign next_val = head_val;
    end else if (i == psx_pkg::STACK_DEPTH - 1) begin : g_bottom
      assign prev_val = cell_val[i-1];
      assign next_val = '0;
    end else begin : g_mid
      assign prev_val = cell_val[i-1];
      assign next_val = cell_val[i+1];
    end
    psx_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .prev_i  (prev_val),
      .next_i  (next_val),
      .value_o (cell_val[i])
    );
  end

  // output register and skid slot
  psx_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && last_i),
    .data_i      (res),
    .full_o      (obuf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (res_out)
  );

  assign result_o = res_out.result;
  assign status_o = res_out.status;

  // skid slot only fills behind a waiting result
  `PSX_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, in_stall_o, out_valid_o)
  // fill count stays within the stack
  `PSX_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= psx_pkg::CNT_W'(psx_pkg::STACK_DEPTH))
  // last character empties the stack and clears the error
  `PSX_ASSERT_NXT(a_clear_after_last, clk_i, rst_ni, in_fire && last_i,
                  (cnt_q == '0) && (err_q == psx_pkg::ST_OK))
  // once an error is recorded the stack is frozen until the last character
  `PSX_ASSERT_NXT(a_err_freezes, clk_i, rst_ni,
                  (err_q != psx_pkg::ST_OK) && !(in_fire && last_i), $stable(cnt_q))

endmodule
